### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock, masked while reset is low.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Next-cycle implication built on the check above.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  `ASSERT_CLK(lbl, clk, rstn, (ante) |=> (cons), msg)

`endif

### sv/dwe_pkg.sv
package dwe_pkg;

  localparam int unsigned MaxDigitsDef = 32;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_EXCL  = 8'h21;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [5:0] DIGIT_BASE = 6'd48;

  typedef enum logic [1:0] {
    MODE_BOUNDARY = 2'd0,
    MODE_NUMBER   = 2'd1,
    MODE_REJECT   = 2'd2
  } dwe_mode_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic rd_fire;
  } dwe_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic flush;
    logic out_busy;
    logic rd_last;
  } dwe_sts_t;

endpackage

### sv/digit_word_extractor_unit.sv
// Input: one byte per cycle while scanning; a byte that closes a number word
//   holds off the next byte until all of its kept digits have been read out.
// Output: after the closing byte, the drain state reads one digit per cycle
//   while out_stall_i is low, set by the single read port of the digit store.
// Reset (rst_ni low, asynchronous): scanner at a word boundary, count and
//   flags cleared, output empty; digit store contents are left as they are.
module digit_word_extractor_unit
  import dwe_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MaxDigitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [5:0] digit_char_o,
  output logic       last_digit_o,
  output logic       truncated_o
);

  dwe_cmd_t cmd;
  dwe_sts_t sts;

  dwe_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  dwe_dpath #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_code_i  (char_code_i),
    .end_of_text_i(end_of_text_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o),
    .truncated_o  (truncated_o)
  );

endmodule

### sv/dwe_ram.sv
module dwe_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/dwe_ctrl.sv
`include "assert_macros.svh"

module dwe_ctrl
  import dwe_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dwe_sts_t sts_i,
  output dwe_cmd_t cmd_o
);

  typedef enum logic {
    S_SCAN,
    S_DRAIN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o.accept  = (state_q == S_SCAN) && in_valid_i;
    cmd_o.rd_fire = (state_q == S_DRAIN) && !sts_i.out_busy;
    state_d = state_q;
    unique case (state_q)
      S_SCAN: begin
        if (cmd_o.accept && sts_i.flush) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // leave once the final digit has been read out
        if (cmd_o.rd_fire && sts_i.rd_last) begin
          state_d = S_SCAN;
        end
      end
      default: state_d = S_SCAN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SCAN;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_SCAN);

  `ASSERT_NEXT(a_drain_ends, clk_i, rst_ni, cmd_o.rd_fire && sts_i.rd_last,
               state_q == S_SCAN, "drain did not return to scan")

endmodule

### sv/dwe_dpath.sv
`include "assert_macros.svh"

module dwe_dpath
  import dwe_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MaxDigitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] char_code_i,
  input  logic       end_of_text_i,
  input  dwe_cmd_t   cmd_i,
  output dwe_sts_t   sts_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [5:0] digit_char_o,
  output logic       last_digit_o,
  output logic       truncated_o
);

  localparam int unsigned CntW  = $clog2(MAX_DIGITS + 1);
  localparam int unsigned AddrW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_DIGITS);

  dwe_mode_e       mode_q, mode_d;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic [CntW-1:0] run_len_q, run_len_d;
  logic            run_trunc_q, run_trunc_d;
  logic [CntW-1:0] rd_ptr_q;
  logic            out_valid_q, out_last_q, out_trunc_q;

  logic             is_delim, is_digit, flush;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [3:0]       rdata;

  always_comb begin
    case (char_code_i) inside
      CH_SPACE, CH_EXCL, CH_QUEST, CH_DOT, CH_COMMA, CH_LPAR, CH_RPAR, CH_LF: is_delim = 1'b1;
      default: is_delim = 1'b0;
    endcase
    is_digit = (char_code_i >= CH_ZERO) && (char_code_i <= CH_NINE);
  end

  always_comb begin
    mode_d      = mode_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    we          = 1'b0;
    waddr       = count_q[AddrW-1:0];
    flush       = 1'b0;
    run_len_d   = count_q;
    run_trunc_d = ovf_q;

    // byte itself
    if (is_delim) begin
      flush   = (mode_q == MODE_NUMBER);
      count_d = '0;
      ovf_d   = 1'b0;
      mode_d  = MODE_BOUNDARY;
    end else if (is_digit) begin
      if (mode_q == MODE_BOUNDARY) begin
        we      = 1'b1;
        waddr   = '0;
        count_d = CntW'(1);
        ovf_d   = 1'b0;
        mode_d  = MODE_NUMBER;
      end else if (mode_q == MODE_NUMBER) begin
        if (count_q < MaxCnt) begin
          we      = 1'b1;
          count_d = count_q + CntW'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end
    end else begin
      count_d = '0;
      ovf_d   = 1'b0;
      mode_d  = MODE_REJECT;
    end

    // end of text closes a word left open by this byte
    if (end_of_text_i) begin
      if (mode_d == MODE_NUMBER) begin
        flush       = 1'b1;
        run_len_d   = count_d;
        run_trunc_d = ovf_d;
      end
      count_d = '0;
      ovf_d   = 1'b0;
      mode_d  = MODE_BOUNDARY;
    end
  end

  dwe_ram #(
    .WIDTH(4),
    .DEPTH(MAX_DIGITS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.accept && we),
    .waddr_i(waddr),
    .wdata_i(char_code_i[3:0]),
    .re_i   (cmd_i.rd_fire),
    .raddr_i(rd_ptr_q[AddrW-1:0]),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_BOUNDARY;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      run_len_q   <= '0;
      run_trunc_q <= 1'b0;
      rd_ptr_q    <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_trunc_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        mode_q  <= mode_d;
        count_q <= count_d;
        ovf_q   <= ovf_d;
        if (flush) begin
          run_len_q   <= run_len_d;
          run_trunc_q <= run_trunc_d;
          rd_ptr_q    <= '0;
        end
      end
      if (cmd_i.rd_fire) begin
        // read data lands in the output slot on this same edge
        rd_ptr_q    <= rd_ptr_q + CntW'(1);
        out_valid_q <= 1'b1;
        out_last_q  <= sts_o.rd_last;
        out_trunc_q <= run_trunc_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.flush    = flush;
  assign sts_o.out_busy = out_valid_q && out_stall_i;
  assign sts_o.rd_last  = (rd_ptr_q == run_len_q - CntW'(1));

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = DIGIT_BASE + {2'b00, rdata};
  assign last_digit_o = out_last_q;
  assign truncated_o  = out_trunc_q;

  `ASSERT_CLK(a_count_bound, clk_i, rst_ni, count_q <= MaxCnt,
              "digit count beyond buffer depth")
  `ASSERT_NEXT(a_run_nonempty, clk_i, rst_ni, cmd_i.accept && flush,
               run_len_q != '0, "flushed run has no digits")
  `ASSERT_CLK(a_digit_range, clk_i, rst_ni, out_valid_q |-> (rdata <= 4'd9),
              "emitted value is not a decimal digit")

endmodule
